[rtl/dds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants of the dtmf dial sequencer.
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int unsigned CODE_W    = 8;
  localparam int unsigned TIME_W    = 10;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CODE_W-1:0] TONE_OFF    = 8'd32;
  localparam logic [TIME_W-1:0] ELAPSED_MAX = 10'd1023;
  localparam logic [TIME_W-1:0] SPACE_RST   = 10'd40;
  localparam logic [TIME_W-1:0] MARK_RST    = 10'd40;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_MS  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SPACE = 2'd1,
    PH_MARK  = 2'd2
  } phase_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_FORCE = 2'd2
  } action_t;

  typedef struct packed {
    logic [CODE_W-1:0] tone_code;
    logic              dialing;
    logic              ignored;
  } dds_result_t;

endpackage

[rtl/dds_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_if
// Valid/ready channel interfaces for input items and result items.
// ----------------------------------------------------------------------------
interface dds_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] code_char;
  logic       last_digit;

  modport source (output valid, output action, output code_char, output last_digit,
                  input ready);
  modport sink (input valid, input action, input code_char, input last_digit,
                output ready);
endinterface

interface dds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tone_code;
  logic       dialing;
  logic       ignored;

  modport source (output valid, output tone_code, output dialing, output ignored,
                  input ready);
  modport sink (input valid, input tone_code, input dialing, input ignored,
                output ready);
endinterface

[rtl/dds_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_store
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dds_store #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 29,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // no reset: entries are only read after being written
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read during write of the same entry returns the old data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/dds_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_ctrl
// Dial state machine, timing registers and per-item next-state logic.
// ----------------------------------------------------------------------------
module dds_ctrl #(
  parameter int unsigned MAX_DIGITS = 29,
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [dds_pkg::ACT_W-1:0]      action,
  input  logic [dds_pkg::CODE_W-1:0]     code_char,
  input  logic                           last_digit,
  input  logic                           cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dds_pkg::TIME_W-1:0]     cfg_data,
  output logic                           wr_en,
  output logic [IDX_W-1:0]               wr_addr,
  output logic [dds_pkg::CODE_W-1:0]     wr_data,
  output logic [IDX_W-1:0]               rd_addr,
  input  logic [dds_pkg::CODE_W-1:0]     rd_data,
  output dds_pkg::dds_result_t           result
);
  import dds_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

  phase_t            phase, phase_next;
  logic [TIME_W-1:0] elapsed_ms, elapsed_ms_next;
  logic [CNT_W-1:0]  digit_index, digit_index_next;
  logic [CNT_W-1:0]  loaded_count, loaded_count_next;
  logic              overlong, overlong_next;
  logic [CODE_W-1:0] current_tone, current_tone_next;
  logic [CODE_W-1:0] first_digit;
  logic [TIME_W-1:0] space_ms, mark_ms;
  logic              dropped;

  logic [TIME_W-1:0] elapsed_inc;
  logic [CNT_W:0]    index_inc;
  logic              room;

  assign elapsed_inc = (elapsed_ms != ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;
  assign index_inc   = {1'b0, digit_index} + 1'b1;
  assign room        = (loaded_count < MAX_CNT);

  // read data is registered, so the buffer is addressed with the index
  // that holds after this edge; rd_data then matches digit_index
  assign rd_addr = step ? digit_index_next[IDX_W-1:0] : digit_index[IDX_W-1:0];
  assign wr_addr = loaded_count[IDX_W-1:0];
  assign wr_data = code_char;

  // next state
  always_comb begin
    phase_next        = phase;
    elapsed_ms_next   = elapsed_ms;
    digit_index_next  = digit_index;
    loaded_count_next = loaded_count;
    overlong_next     = overlong;
    current_tone_next = current_tone;
    dropped           = 1'b0;
    wr_en             = 1'b0;
    unique case (action)
      ACT_TICK: begin
        elapsed_ms_next = elapsed_inc;
        unique case (phase)
          PH_IDLE: begin
          end
          PH_SPACE: begin
            if (elapsed_inc >= space_ms) begin
              phase_next        = PH_MARK;
              elapsed_ms_next   = '0;
              current_tone_next = rd_data;
            end
          end
          PH_MARK: begin
            if (elapsed_inc >= mark_ms) begin
              current_tone_next = TONE_OFF;
              if (index_inc >= {1'b0, loaded_count}) begin
                phase_next        = PH_IDLE;
                loaded_count_next = '0;
                digit_index_next  = '0;
              end else begin
                phase_next       = PH_SPACE;
                elapsed_ms_next  = '0;
                digit_index_next = index_inc[CNT_W-1:0];
              end
            end
          end
          default: begin
            // unreachable phase code recovers to idle
            current_tone_next = TONE_OFF;
            phase_next        = PH_IDLE;
            loaded_count_next = '0;
          end
        endcase
      end
      ACT_LOAD: begin
        if (phase != PH_IDLE) begin
          dropped = 1'b1;
        end else begin
          if (room) begin
            wr_en             = step;
            loaded_count_next = loaded_count + 1'b1;
          end else begin
            overlong_next = 1'b1;
            dropped       = 1'b1;
          end
          if (last_digit) begin
            overlong_next = 1'b0;
            if (!room || overlong) begin
              dropped           = 1'b1;
              loaded_count_next = '0;
            end else begin
              phase_next        = PH_MARK;
              digit_index_next  = '0;
              elapsed_ms_next   = '0;
              current_tone_next = (loaded_count == '0) ? code_char : first_digit;
            end
          end
        end
      end
      ACT_FORCE: begin
        phase_next        = PH_IDLE;
        current_tone_next = code_char;
        loaded_count_next = '0;
        digit_index_next  = '0;
        overlong_next     = 1'b0;
      end
      default: begin
        dropped = 1'b1;
      end
    endcase
  end

  // result of the item
  always_comb begin
    result.tone_code = current_tone_next;
    result.dialing   = (phase_next != PH_IDLE);
    result.ignored   = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      elapsed_ms   <= '0;
      digit_index  <= '0;
      loaded_count <= '0;
      overlong     <= 1'b0;
      current_tone <= TONE_OFF;
    end else if (step) begin
      phase        <= phase_next;
      elapsed_ms   <= elapsed_ms_next;
      digit_index  <= digit_index_next;
      loaded_count <= loaded_count_next;
      overlong     <= overlong_next;
      current_tone <= current_tone_next;
    end
  end

  // copy of entry zero so a sequence can start without a second read port
  always_ff @(posedge clk) begin
    if (wr_en && (loaded_count == '0)) begin
      first_digit <= code_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      space_ms <= SPACE_RST;
      mark_ms  <= MARK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPACE_MS: space_ms <= cfg_data;
        CFG_MARK_MS:  mark_ms  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/dtmf_dial_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtmf_dial_sequencer
// Plays loaded dtmf digits as timed tone marks and silent spaces.
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one transaction per item: a 1 ms tick, a digit load (with
//   last_digit on the final digit, which starts dialing) or a forced code
//   out_ch returns exactly one transaction per input transaction: the code
//   driven to the tone generator (32 = off), the dialing flag and an
//   ignored flag for dropped items
//   cfg port writes space_ms (index 0) and mark_ms (index 1); the user
//   must write them only while idle; the block does not enforce this
// timing
//   the state update and result are formed in the cycle an item is taken
//   and the result is on out_ch the next cycle; one item per cycle unless
//   out_ch stalls, set by the single result register; in_ch.ready stays
//   high while the result register is empty or drained in the same cycle,
//   so a stalled receiver holds one result and then back-pressures the input
// reset
//   synchronous rst: idle, tones off (32), no digits loaded, space_ms and
//   mark_ms back to 40; the digit buffer itself is not cleared
// ----------------------------------------------------------------------------
module dtmf_dial_sequencer #(
  parameter int unsigned MAX_DIGITS = 29
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dds_pkg::TIME_W-1:0]     cfg_data,
  dds_in_if.sink                         in_ch,
  dds_out_if.source                      out_ch
);
  import dds_pkg::*;

  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic              accept;
  logic              out_valid;
  dds_result_t       result;
  dds_result_t       out_data;

  // digit buffer link
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CODE_W-1:0] wr_data;
  logic [IDX_W-1:0]  rd_addr;
  logic [CODE_W-1:0] rd_data;

  // take a new item whenever the result register is free or being emptied
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  dds_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .action     (in_ch.action),
    .code_char  (in_ch.code_char),
    .last_digit (in_ch.last_digit),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .result     (result)
  );

  dds_store #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.tone_code = out_data.tone_code;
  assign out_ch.dialing   = out_data.dialing;
  assign out_ch.ignored   = out_data.ignored;

endmodule
